@@ rtl/mtnp_pkg.sv @@
// mtnp_pkg: shared beat types for the midi track note parser
// used by mtnp_parser and midi_track_note_parser; no dependencies
package mtnp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned NoteW  = 7;
  localparam int unsigned TicksW = 28;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             track_last;
  } in_beat_t;

  typedef struct packed {
    logic              is_on;
    logic [NoteW-1:0]  note;
    logic [NoteW-1:0]  velocity;
    logic [TicksW-1:0] delta_ticks;
  } out_beat_t;

  typedef struct packed {
    logic      valid;
    out_beat_t beat;
  } note_res_t;

  localparam logic [3:0] HiNoteOff  = 4'h8;
  localparam logic [3:0] HiNoteOn   = 4'h9;
  localparam logic [3:0] HiProgram  = 4'hC;
  localparam logic [3:0] HiPressure = 4'hD;
  localparam logic [7:0] StMeta     = 8'hFF;
  localparam logic [7:0] StNone     = 8'h00;

endpackage

@@ rtl/mtnp_parser.sv @@
// mtnp_parser: track event state machine, one byte per enabled cycle
// gives the note result for that byte combinationally; depends on mtnp_pkg
module mtnp_parser import mtnp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  in_beat_t  beat,
  output note_res_t res
);

  typedef enum logic [2:0] {
    PH_DELTA  = 3'd0,
    PH_STATUS = 3'd1,
    PH_DATA1  = 3'd2,
    PH_DATA2  = 3'd3,
    PH_LEN    = 3'd4,
    PH_SKIP   = 3'd5
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [TicksW-1:0] delta_r, delta_nxt;
  logic [ByteW-1:0]  rstat_r, rstat_nxt;
  logic [NoteW-1:0]  first_r, first_nxt;
  logic [TicksW-1:0] skip_r, skip_nxt;
  logic              meta_r, meta_nxt;

  logic [ByteW-1:0]  b;
  logic [3:0]        hi;
  logic              one_data;
  logic [NoteW-1:0]  vel;
  logic [TicksW-1:0] skip_dec;

  assign b        = beat.data_byte;
  assign hi       = rstat_r[7:4];
  assign one_data = (hi == HiProgram) || (hi == HiPressure);
  assign vel      = b[7] ? {NoteW{1'b1}} : b[NoteW-1:0];
  assign skip_dec = (skip_r != '0) ? skip_r - 1'b1 : skip_r;

  always_comb begin
    phase_nxt = phase_r;
    delta_nxt = delta_r;
    rstat_nxt = rstat_r;
    first_nxt = first_r;
    skip_nxt  = skip_r;
    meta_nxt  = meta_r;
    res       = '0;
    unique case (phase_r)
      PH_DELTA: begin
        delta_nxt = {delta_r[TicksW-8:0], b[6:0]};
        if (!b[7]) phase_nxt = PH_STATUS;
      end
      PH_STATUS: begin
        if (b[7:4] == 4'hF) begin
          rstat_nxt = StNone;
          skip_nxt  = '0;
          meta_nxt  = (b == StMeta);
          phase_nxt = PH_LEN;
        end else if (b[7]) begin
          rstat_nxt = b;
          phase_nxt = PH_DATA1;
        end else if (rstat_r == StNone) begin
          phase_nxt = PH_DELTA;
          delta_nxt = '0;
        end else begin
          first_nxt = b[NoteW-1:0];
          if (one_data) begin
            phase_nxt = PH_DELTA;
            delta_nxt = '0;
          end else begin
            phase_nxt = PH_DATA2;
          end
        end
      end
      PH_DATA1: begin
        first_nxt = b[NoteW-1:0];
        if (one_data) begin
          phase_nxt = PH_DELTA;
          delta_nxt = '0;
        end else begin
          phase_nxt = PH_DATA2;
        end
      end
      PH_DATA2: begin
        if ((hi == HiNoteOn) || (hi == HiNoteOff)) begin
          res.valid            = 1'b1;
          res.beat.is_on       = (hi == HiNoteOn) && (vel != '0);
          res.beat.note        = first_r;
          res.beat.velocity    = vel;
          res.beat.delta_ticks = delta_r;
        end
        phase_nxt = PH_DELTA;
        delta_nxt = '0;
      end
      PH_LEN: begin
        if (meta_r) begin
          meta_nxt = 1'b0;
          skip_nxt = '0;
        end else begin
          skip_nxt = {skip_r[TicksW-8:0], b[6:0]};
          if (!b[7]) begin
            if ({skip_r[TicksW-8:0], b[6:0]} == '0) begin
              phase_nxt = PH_DELTA;
              delta_nxt = '0;
            end else begin
              phase_nxt = PH_SKIP;
            end
          end
        end
      end
      PH_SKIP: begin
        skip_nxt = skip_dec;
        if (skip_dec == '0) begin
          phase_nxt = PH_DELTA;
          delta_nxt = '0;
        end
      end
      default: begin
        phase_nxt = PH_DELTA;
        delta_nxt = '0;
      end
    endcase
    if (!en) res.valid = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (en && beat.track_last)) begin
      phase_r <= PH_DELTA;
      delta_r <= '0;
      rstat_r <= StNone;
      first_r <= '0;
      skip_r  <= '0;
      meta_r  <= 1'b0;
    end else if (en) begin
      phase_r <= phase_nxt;
      delta_r <= delta_nxt;
      rstat_r <= rstat_nxt;
      first_r <= first_nxt;
      skip_r  <= skip_nxt;
      meta_r  <= meta_nxt;
    end
  end

endmodule

@@ rtl/midi_track_note_parser.sv @@
// Parses a MIDI track chunk fed one byte per beat and gives one beat per note-on
// or note-off event, with its velocity clamped to 127 and its own delta ticks.
// Each byte passes an input register, the parser state update and an output
// register, so a byte is taken every cycle unless the result side stalls; a
// note result enters the output register as its last byte leaves the input
// register. A byte with track_last set resets the parser after it is processed.
// depends on mtnp_pkg and mtnp_parser
module midi_track_note_parser import mtnp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  logic      s1_valid_r;
  in_beat_t  s1_r;
  logic      out_valid_r;
  out_beat_t out_r;
  logic      adv;
  note_res_t res;

  assign adv       = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  mtnp_parser u_parser (
    .clk  (clk),
    .rst_n(rst_n),
    .en   (adv),
    .beat (s1_r),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= res.valid;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s1_r <= in_data;
    if (adv && res.valid) out_r <= res.beat;
  end

  // held byte with a stalled result slot blocks the input
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ready) |-> !in_ready)
    else $error("input taken while pipeline stalled");

  // a new result only follows a held byte
  a_res_source: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> $past(s1_valid_r))
    else $error("result without source byte");

  // a result is never dropped while waiting
  a_res_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_r)))
    else $error("pending result lost");

  // reset empties both stages
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> (!out_valid_r && !s1_valid_r))
    else $error("stage valid after reset");

endmodule

@@ tb/note_event_checker.sv @@
// note_event_checker: predicts the note beats of midi_track_note_parser from
// the accepted input beats and compares them with the result channel
// depends on mtnp_pkg
module note_event_checker import mtnp_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_ready,
  input  in_beat_t        in_data,
  input  logic            out_valid,
  input  logic            out_ready,
  input  out_beat_t       out_data,
  output int unsigned     fail_count,
  output int unsigned     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    PhDelta, PhStatus, PhData1, PhData2, PhLen, PhSkip
  } phase_t;

  phase_t       phase;
  logic [27:0]  delta_acc;
  logic [7:0]   run_status;
  logic [6:0]   first_note;
  logic [27:0]  skip_left;
  logic         meta_wait;
  out_beat_t    expected_notes [$];
  out_beat_t    want;

  function automatic logic [27:0] vlq_shift(input logic [27:0] acc, input logic [7:0] b);
    return {acc[20:0], b[6:0]};
  endfunction

  task automatic clear_parser();
    phase      = PhDelta;
    delta_acc  = '0;
    run_status = StNone;
    first_note = '0;
    skip_left  = '0;
    meta_wait  = 1'b0;
  endtask

  task automatic end_event();
    phase     = PhDelta;
    delta_acc = '0;
  endtask

  task automatic take_first_data(input logic [7:0] b, input logic [3:0] hi);
    first_note = b[6:0];
    if (hi == HiProgram || hi == HiPressure) begin
      end_event();
    end else begin
      phase = PhData2;
    end
  endtask

  task automatic decode_track_byte(input in_beat_t beat);
    logic [7:0] b;
    logic [3:0] hi;
    logic [6:0] vel;
    out_beat_t  note_ev;
    b  = beat.data_byte;
    hi = run_status[7:4];
    case (phase)
      PhDelta: begin
        delta_acc = vlq_shift(delta_acc, b);
        if (!b[7]) phase = PhStatus;
      end
      PhStatus: begin
        if (b >= 8'hF0) begin
          run_status = StNone;
          skip_left  = '0;
          meta_wait  = (b == StMeta);
          phase      = PhLen;
        end else if (b[7]) begin
          run_status = b;
          phase      = PhData1;
        end else if (run_status == StNone) begin
          end_event();
        end else begin
          take_first_data(b, hi);
        end
      end
      PhData1: take_first_data(b, hi);
      PhData2: begin
        if (hi == HiNoteOn || hi == HiNoteOff) begin
          vel                 = b[7] ? 7'h7F : b[6:0];
          note_ev.is_on       = (hi == HiNoteOn) && (vel != 7'd0);
          note_ev.note        = first_note;
          note_ev.velocity    = vel;
          note_ev.delta_ticks = delta_acc;
          expected_notes.push_back(note_ev);
        end
        end_event();
      end
      PhLen: begin
        if (meta_wait) begin
          meta_wait = 1'b0;
          skip_left = '0;
        end else begin
          skip_left = vlq_shift(skip_left, b);
          if (!b[7]) begin
            if (skip_left == 28'd0) end_event();
            else phase = PhSkip;
          end
        end
      end
      PhSkip: begin
        if (skip_left != 28'd0) skip_left = skip_left - 28'd1;
        if (skip_left == 28'd0) end_event();
      end
      default: end_event();
    endcase
    if (beat.track_last) clear_parser();
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parser();
      expected_notes.delete();
      fail_count = 0;
      pending    = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_notes.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected note beat on=%0d note=%0d vel=%0d ticks=%0d", $time,
                   out_data.is_on, out_data.note, out_data.velocity, out_data.delta_ticks);
        end else begin
          want = expected_notes.pop_front();
          if (out_data.is_on !== want.is_on || out_data.note !== want.note ||
              out_data.velocity !== want.velocity ||
              out_data.delta_ticks !== want.delta_ticks) begin
            fail_count++;
            $display("%0t: mismatch expected on=%0d note=%0d vel=%0d ticks=%0d", $time,
                     want.is_on, want.note, want.velocity, want.delta_ticks);
            $display("%0t:          actual   on=%0d note=%0d vel=%0d ticks=%0d", $time,
                     out_data.is_on, out_data.note, out_data.velocity, out_data.delta_ticks);
          end
        end
      end
      if (in_valid && in_ready) decode_track_byte(in_data);
      pending = expected_notes.size();
    end
  end

endmodule

@@ tb/tb_top.sv @@
// tb_top: drives midi_track_note_parser with directed and random track bytes
// under varying idle and stall patterns; depends on mtnp_pkg, the rtl and
// note_event_checker
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mtnp_pkg::*;

  localparam logic [3:0] HiPolyPress = 4'hA;
  localparam logic [3:0] HiControl   = 4'hB;
  localparam logic [3:0] HiPitchBend = 4'hE;
  localparam logic [7:0] StSysex     = 8'hF0;
  localparam logic [7:0] StSysexEsc  = 8'hF7;
  localparam int         PhaseBeats  = 190;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_beat_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_beat_t   out_data;
  int unsigned fail_count;
  int unsigned pending;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          sent_beats = 0;

  logic [3:0]  other_his [5] = '{HiPolyPress, HiControl, HiPitchBend, HiProgram, HiPressure};
  int          idle_plan [4] = '{0, 72, 0, 8};
  int          stall_plan [4] = '{0, 0, 72, 8};

  // {track_last, byte}
  logic [8:0]  directed_beats [$] = '{
    9'h000, 9'h090, 9'h03C, 9'h040,
    9'h081, 9'h000, 9'h03C, 9'h000,
    9'h07F, 9'h08F, 9'h0FF, 9'h0FF,
    9'h000, 9'h0C5, 9'h010,
    9'h000, 9'h0F0, 9'h001, 9'h055,
    9'h000, 9'h0FF, 9'h02F, 9'h000,
    9'h000, 9'h010,
    9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h07F, 9'h09F, 9'h000, 9'h17F
  };

  midi_track_note_parser u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  note_event_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic logic rnd_last();
    return $urandom_range(199) < 3;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, track_last: last};
    do @(posedge clk); while (!in_ready);
    sent_beats++;
  endtask

  task automatic send_delta();
    int n;
    n = ($urandom_range(9) == 0) ? $urandom_range(5, 6) : $urandom_range(1, 4);
    for (int i = 1; i < n; i++) send_byte({1'b1, 7'($urandom)}, rnd_last());
    send_byte({1'b0, 7'($urandom)}, rnd_last());
  endtask

  // length field then its payload; long forms wrap back to a small value
  task automatic send_skip();
    int f;
    int len;
    f   = $urandom_range(9);
    len = $urandom_range(0, 12);
    if (f >= 9) begin
      send_byte({1'b1, 7'($urandom_range(1, 127))}, rnd_last());
      repeat (3) send_byte(8'h80, rnd_last());
    end else if (f >= 7) begin
      send_byte(8'h80, rnd_last());
    end
    send_byte({1'b0, 7'(len)}, rnd_last());
    repeat (len) send_byte(8'($urandom), rnd_last());
  endtask

  function automatic logic [7:0] data_value();
    return ($urandom_range(9) == 0) ? 8'($urandom) : {1'b0, 7'($urandom)};
  endfunction

  function automatic logic [7:0] velocity_value();
    int k;
    k = $urandom_range(9);
    if (k == 0) return 8'h00;
    if (k == 1) return 8'($urandom_range(128, 255));
    return 8'($urandom_range(1, 127));
  endfunction

  task automatic send_track_event();
    int         k;
    logic [3:0] hi;
    k = $urandom_range(99);
    if (k < 6) begin
      send_byte(8'($urandom), rnd_last());
      return;
    end
    send_delta();
    k = $urandom_range(99);
    if (k < 45) begin
      hi = $urandom_range(1) ? HiNoteOn : HiNoteOff;
      if ($urandom_range(2) != 0) send_byte({hi, 4'($urandom)}, rnd_last());
      send_byte(data_value(), rnd_last());
      send_byte(velocity_value(), rnd_last());
    end else if (k < 60) begin
      hi = other_his[$urandom_range(4)];
      if ($urandom_range(2) != 0) send_byte({hi, 4'($urandom)}, rnd_last());
      send_byte(data_value(), rnd_last());
      if (hi != HiProgram && hi != HiPressure) send_byte(data_value(), rnd_last());
    end else if (k < 75) begin
      send_byte(StMeta, rnd_last());
      send_byte(8'($urandom), rnd_last());
      send_skip();
    end else if (k < 92) begin
      case ($urandom_range(2))
        0: send_byte(StSysex, rnd_last());
        1: send_byte(StSysexEsc, rnd_last());
        default: send_byte(8'($urandom_range(8'hF1, 8'hFE)), rnd_last());
      endcase
      send_skip();
    end else begin
      send_byte(8'($urandom_range(128, 255)), rnd_last());
      repeat ($urandom_range(2)) send_byte(8'($urandom), rnd_last());
    end
  endtask

  task automatic drain_notes();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  initial begin
    int target;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed_beats[i]) send_byte(directed_beats[i][7:0], directed_beats[i][8]);
    for (int p = 0; p < 4; p++) begin
      idle_pct  = idle_plan[p];
      stall_pct = stall_plan[p];
      target    = sent_beats + PhaseBeats;
      while (sent_beats < target) send_track_event();
      drain_notes();
    end
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/mtnp_pkg.sv
rtl/mtnp_parser.sv
rtl/midi_track_note_parser.sv
tb/note_event_checker.sv
tb/tb_top.sv
